FILE: rtl/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;
    localparam int GRP       = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DUMP_FWD   = 3'd4,
        CMD_DUMP_BWD   = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHIFT_R,
        OP_SHIFT_L,
        OP_WRITE
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value_in;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic [STAT_W-1:0]        status;
        logic                     last;
    } out_item_t;

    // broadcast to every cell
    typedef struct packed {
        cell_op_t           op;
        logic               rd_en;
        logic [DATA_W-1:0]  wdata;
    } cell_ctrl_t;

    // result tag that travels alongside the read tree
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              last;
    } res_meta_t;

endpackage

FILE: rtl/deq_cell.sv
module deq_cell #(
    parameter int IDX_W = 6,
    parameter int IDX   = 0
) (
    input  logic                       clk,
    input  deq_pkg::cell_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]           sel,
    input  logic [IDX_W-1:0]           wr_idx,
    input  logic [deq_pkg::DATA_W-1:0] left_data,
    input  logic [deq_pkg::DATA_W-1:0] right_data,
    output logic [deq_pkg::DATA_W-1:0] data,
    output logic [deq_pkg::DATA_W-1:0] tap
);
    import deq_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              rd_hit;
    logic              wr_hit;

    assign rd_hit = ctrl.rd_en && (sel == IDX_W'(IDX));
    assign wr_hit = (wr_idx == IDX_W'(IDX));

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            OP_HOLD:    data_next = data_reg;
            OP_SHIFT_R: data_next = left_data;
            OP_SHIFT_L: data_next = right_data;
            OP_WRITE:
            begin
                if (wr_hit)
                begin
                    data_next = ctrl.wdata;
                end
            end
            default:    data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = rd_hit ? data_reg : '0;

endmodule

FILE: rtl/deq_read_tree.sv
module deq_read_tree #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [DEPTH-1:0][deq_pkg::DATA_W-1:0] taps,
    input  logic                                  meta_vld,
    input  deq_pkg::res_meta_t                    meta,
    output logic                                  advance,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output deq_pkg::out_item_t                    out_data
);
    import deq_pkg::*;

    localparam int NGRP = (DEPTH + GRP - 1) / GRP;

    logic [NGRP-1:0][DATA_W-1:0] grp_reg;
    logic [NGRP-1:0][DATA_W-1:0] grp_next;
    res_meta_t                   s1_meta_reg;
    logic                        s1_vld_reg;
    logic [DATA_W-1:0]           sum_val;
    out_item_t                   out_reg;
    logic                        out_vld_reg;

    // whole pipe stalls together while the output item waits
    assign advance = !out_vld_reg || out_ready;

    always_comb
    begin
        grp_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            for (int k = 0; k < GRP; k++)
            begin
                if (g * GRP + k < DEPTH)
                begin
                    grp_next[g] = grp_next[g] | taps[g * GRP + k];
                end
            end
        end
    end

    always_comb
    begin
        sum_val = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            sum_val = sum_val | grp_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            grp_reg     <= grp_next;
            s1_meta_reg <= meta;
            out_reg     <= '{value_out: sum_val, status: s1_meta_reg.status,
                             last: s1_meta_reg.last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_vld_reg  <= meta_vld;
            out_vld_reg <= s1_vld_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/double_ended_queue_top.sv
// Channel  Signals                         Item
// -------  ------------------------------  ---------------------------
// in       in_valid, in_ready, in_data     command and value to push
// out      out_valid, out_ready, out_data  value, status, last flag
//
// Push, pop and error commands leave in_ready high for the next command; a
// result passes through the read tree's group and output registers.
// A dump of N entries holds in_ready low past acceptance until its last entry
// is read, reading one cell per cycle while the output does not stall, through the same tree.
// rst_n clears the entry count and control; cell contents are not reset.
// A stalled output freezes the read tree and the command side together.
module double_ended_queue_top #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  deq_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output deq_pkg::out_item_t out_data
);
    import deq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   ptr_reg;
    logic [IDX_W-1:0]   ptr_next;
    logic               bwd_reg;
    logic               bwd_next;

    cell_ctrl_t         ctrl;
    logic [IDX_W-1:0]   sel;
    logic [IDX_W-1:0]   wr_idx;
    logic               meta_vld;
    res_meta_t          meta;
    logic               advance;
    logic               accept;
    logic               full;
    logic               empty;
    logic [CNT_W-1:0]   count_m1;
    logic [CNT_W-1:0]   ptr_ext;

    logic [DEPTH-1:0][DATA_W-1:0] chain;
    logic [DEPTH-1:0][DATA_W-1:0] taps;

    assign in_ready = (state_reg == S_IDLE) && advance;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - 1'b1;
    assign ptr_ext  = CNT_W'(ptr_reg);
    assign wr_idx   = count_reg[IDX_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        bwd_next     = bwd_reg;
        ctrl.op      = OP_HOLD;
        ctrl.rd_en   = 1'b0;
        ctrl.wdata   = in_data.value_in;
        sel          = '0;
        meta_vld     = 1'b0;
        meta.status  = ST_OK;
        meta.last    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            meta_vld = 1'b1;
                            if (full)
                            begin
                                meta.status = ST_FULL;
                            end
                            else
                            begin
                                ctrl.op    = (in_data.cmd == CMD_PUSH_FRONT) ?
                                             OP_SHIFT_R : OP_WRITE;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            meta_vld = 1'b1;
                            if (empty)
                            begin
                                meta.status = ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.rd_en = 1'b1;
                                count_next = count_m1;
                                if (in_data.cmd == CMD_POP_FRONT)
                                begin
                                    ctrl.op = OP_SHIFT_L;
                                end
                                else
                                begin
                                    sel = count_m1[IDX_W-1:0];
                                end
                            end
                        end
                        CMD_DUMP_FWD, CMD_DUMP_BWD:
                        begin
                            meta_vld = 1'b1;
                            if (empty)
                            begin
                                meta.status = ST_EMPTY;
                            end
                            else
                            begin
                                // first entry goes out now, the rest in S_DUMP
                                ctrl.rd_en = 1'b1;
                                bwd_next   = (in_data.cmd == CMD_DUMP_BWD);
                                sel        = bwd_next ? count_m1[IDX_W-1:0] : '0;
                                meta.last  = (count_reg == CNT_W'(1));
                                if (!meta.last)
                                begin
                                    state_next = S_DUMP;
                                    ptr_next   = IDX_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            meta_vld = 1'b0;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (advance)
                begin
                    meta_vld   = 1'b1;
                    ctrl.rd_en = 1'b1;
                    sel        = bwd_reg ? IDX_W'(count_m1 - ptr_ext) : ptr_reg;
                    meta.last  = (ptr_ext == count_m1);
                    if (meta.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            bwd_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            bwd_reg   <= bwd_next;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_data;
        logic [DATA_W-1:0] right_data;

        if (i == 0)
        begin : g_head
            assign left_data = ctrl.wdata;
        end
        else
        begin : g_mid
            assign left_data = chain[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_data = chain[i];
        end
        else
        begin : g_body
            assign right_data = chain[i+1];
        end

        deq_cell #(
            .IDX_W (IDX_W),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .sel        (sel),
            .wr_idx     (wr_idx),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (chain[i]),
            .tap        (taps[i])
        );
    end

    deq_read_tree #(
        .DEPTH (DEPTH)
    ) u_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .taps      (taps),
        .meta_vld  (meta_vld),
        .meta      (meta),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_dump_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |-> ctrl.op == OP_HOLD)
        else $error("cells moved during dump");

    a_dump_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |-> ptr_ext < count_reg)
        else $error("dump pointer past last entry");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !full && (in_data.cmd == CMD_PUSH_FRONT || in_data.cmd == CMD_PUSH_BACK)
        |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("push did not grow the queue");
`endif

endmodule
